// File: rtl/core/cit_pkg.sv
// Package for the countdown interval timer: item and result beat types,
// request and register codes, control bit positions, counter width.
// No dependencies.
`default_nettype none

package cit_pkg;

  localparam int unsigned CounterWidth = 32;
  localparam int unsigned DataWidth    = 32;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    REG_STATUS   = 2'd0,
    REG_CONTROL  = 2'd1,
    REG_PERIOD   = 2'd2,
    REG_SNAPSHOT = 2'd3
  } reg_e;

  localparam int unsigned CtlIrqEnBit = 0;
  localparam int unsigned CtlContBit  = 1;
  localparam int unsigned CtlStartBit = 2;
  localparam int unsigned CtlStopBit  = 3;

  typedef logic [CounterWidth-1:0] cnt_t;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [1:0]           reg_index;
    logic [DataWidth-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [DataWidth-1:0] read_data;
    logic                 irq_out;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/cit_core.sv
// Timer state and per-beat update logic: applies one item to the state
// and forms its result. Depends on cit_pkg.
`default_nettype none

module cit_core
  import cit_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    fire_i,
  input  wire item_t   item_i,
  output      result_t res_o
);

  logic timeout_q, timeout_d;
  logic running_q, running_d;
  logic irq_en_q,  irq_en_d;
  logic cont_q,    cont_d;
  cnt_t period_q,  period_d;
  cnt_t count_q,   count_d;
  logic [DataWidth-1:0] rd;

  always_comb begin
    timeout_d = timeout_q;
    running_d = running_q;
    irq_en_d  = irq_en_q;
    cont_d    = cont_q;
    period_d  = period_q;
    count_d   = count_q;
    rd        = '0;
    if (fire_i) begin
      case (item_i.req_type)
        REQ_TICK: begin
          if (running_q) begin
            if (count_q <= CounterWidth'(1)) begin
              timeout_d = 1'b1;
              if (cont_q) begin
                count_d = period_q;
              end else begin
                count_d   = '0;
                running_d = 1'b0;
              end
            end else begin
              count_d = count_q - CounterWidth'(1);
            end
          end
        end
        REQ_READ: begin
          unique case (item_i.reg_index)
            REG_STATUS:   rd = DataWidth'({running_q, timeout_q});
            REG_CONTROL:  rd = DataWidth'({cont_q, irq_en_q});
            REG_PERIOD:   rd = DataWidth'(period_q);
            REG_SNAPSHOT: rd = DataWidth'(count_q);
            default:      rd = '0;
          endcase
        end
        REQ_WRITE: begin
          unique case (item_i.reg_index)
            REG_STATUS: timeout_d = 1'b0;
            REG_CONTROL: begin
              irq_en_d = item_i.write_data[CtlIrqEnBit];
              cont_d   = item_i.write_data[CtlContBit];
              // stop wins over start
              if (item_i.write_data[CtlStopBit]) begin
                running_d = 1'b0;
              end else if (item_i.write_data[CtlStartBit]) begin
                count_d   = period_q;
                running_d = 1'b1;
              end
            end
            REG_PERIOD:   period_d = CounterWidth'(item_i.write_data);
            REG_SNAPSHOT: ;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    res_o.read_data = rd;
    res_o.irq_out   = timeout_d & irq_en_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= 1'b0;
      running_q <= 1'b0;
      irq_en_q  <= 1'b0;
      cont_q    <= 1'b0;
      period_q  <= '0;
      count_q   <= '0;
    end else begin
      timeout_q <= timeout_d;
      running_q <= running_d;
      irq_en_q  <= irq_en_d;
      cont_q    <= cont_d;
      period_q  <= period_d;
      count_q   <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_timeout_rise_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(timeout_q) |-> $past(fire_i && item_i.req_type == REQ_TICK))
    else $error("timeout set without a tick");

  a_count_holds_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(count_q) && $stable(period_q) && $stable(running_q))
    else $error("timer state moved without a beat");

  a_stop_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(running_q) |-> $past(fire_i && (item_i.req_type == REQ_TICK ||
      (item_i.req_type == REQ_WRITE && item_i.reg_index == REG_CONTROL))))
    else $error("timer stopped without a tick or control write");
`endif

endmodule

`default_nettype wire

// File: rtl/core/countdown_interval_timer_top.sv
// An accepted beat sits in the input register; its result then loads the output register.
// Throughput: one beat per cycle while out_stall_i is low, set by the single cit_core pass.
// While a result waits in the output register, the input register takes one beat, then stalls.
// Reset (rst_ni low, asynchronous) clears all timer state and both register valids.
// Top level of the countdown interval timer; depends on cit_pkg and cit_core.
`default_nettype none

module countdown_interval_timer_top
  import cit_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  // request channel
  input  wire logic    in_valid_i,
  output      logic    in_stall_o,
  input  wire item_t   in_item_i,
  // result channel
  output      logic    out_valid_o,
  input  wire logic    out_stall_i,
  output      result_t out_item_o
);

  // Input register: holds one accepted beat until the output side frees up.
  logic    in_valid_q, in_valid_d;
  item_t   in_item_q;
  // Output register: holds the result until the sink takes it.
  logic    out_valid_q, out_valid_d;
  result_t out_item_q;
  result_t res;
  logic    out_free;
  logic    fire;
  logic    in_take;

  // The output register can load when empty or when its beat leaves now.
  assign out_free = !out_valid_q || !out_stall_i;
  // Apply the held beat to the timer state exactly once, as it moves out.
  assign fire     = in_valid_q && out_free;
  // Stall only when the input register is full and cannot drain this cycle.
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q && out_stall_i;
    if (fire) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on handshake, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_i;
    end
    if (fire) begin
      out_item_q <= res;
    end
  end

  cit_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_item_q),
    .res_o  (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// File: test/tb_countdown_interval_timer_top.sv
// Self-checking testbench for countdown_interval_timer_top: random and directed request beats,
// checked against an in-bench model of the timer registers and counter.
// Depends on cit_pkg and the timer RTL.

module tb_countdown_interval_timer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cit_pkg::*;

  localparam int unsigned RandomBeats   = 475;
  localparam int unsigned IdlePct       = 11;
  localparam int unsigned LongHoldAt    = 40;      // results seen before the long receiver hold
  localparam int unsigned LongHoldLen   = 80;      // cycles of that hold
  localparam int unsigned TailCycles    = 8;
  localparam int unsigned CycleLimit    = 200000;

  // Request type 3 is not decoded by the block; drive it anyway.
  localparam logic [1:0] ReqUnknown = 2'd3;

  typedef struct {
    item_t beat;
    bit    drain_first;  // wait for every outstanding result before offering this beat
  } req_slot_t;

  logic    clk_i;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  item_t   in_item   = '0;
  logic    out_stall = 1'b0;
  logic    in_stall;
  logic    out_valid;
  result_t out_item;

  req_slot_t req_beats[$];         // beats still to be offered
  result_t   expected_replies[$];  // predicted results, oldest first

  int unsigned beats_accepted = 0;  // advanced by the driver only
  int unsigned results_seen   = 0;  // advanced by the monitor only
  int unsigned mismatches     = 0;
  int unsigned timeouts_seen  = 0;
  int unsigned irq_results    = 0;
  int unsigned cycle_count    = 0;
  bit          drain_next     = 1'b0;

  // Timer state as the model sees it; reset leaves everything zero.
  logic tmr_timeout = 1'b0;
  logic tmr_running = 1'b0;
  logic tmr_irq_en  = 1'b0;
  logic tmr_cont    = 1'b0;
  cnt_t tmr_period  = '0;
  cnt_t tmr_count   = '0;

  req_slot_t next_slot;
  result_t   want;
  bit        offer;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  countdown_interval_timer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Apply one request beat to the timer model and return the result it must produce.
  function automatic result_t timer_step(input item_t beat);
    result_t res;
    res = '0;
    case (beat.req_type)
      REQ_TICK: begin
        // Stopped timer ignores ticks; a count of zero or one expires without wrapping.
        if (tmr_running) begin
          if (tmr_count <= cnt_t'(1)) begin
            tmr_timeout = 1'b1;
            timeouts_seen++;
            if (tmr_cont) begin
              tmr_count = tmr_period;
            end else begin
              tmr_count   = '0;
              tmr_running = 1'b0;
            end
          end else begin
            tmr_count = tmr_count - cnt_t'(1);
          end
        end
      end
      REQ_READ: begin
        case (beat.reg_index)
          REG_STATUS: begin
            res.read_data[0] = tmr_timeout;
            res.read_data[1] = tmr_running;
          end
          REG_CONTROL: begin
            res.read_data[0] = tmr_irq_en;
            res.read_data[1] = tmr_cont;
          end
          REG_PERIOD:   res.read_data = tmr_period[DataWidth-1:0];
          default:      res.read_data = tmr_count[DataWidth-1:0];
        endcase
      end
      REQ_WRITE: begin
        case (beat.reg_index)
          REG_STATUS: tmr_timeout = 1'b0;  // any data clears the flag
          REG_CONTROL: begin
            tmr_irq_en = beat.write_data[CtlIrqEnBit];
            tmr_cont   = beat.write_data[CtlContBit];
            // Stop beats start when both are set.
            if (beat.write_data[CtlStopBit]) begin
              tmr_running = 1'b0;
            end else if (beat.write_data[CtlStartBit]) begin
              tmr_count   = tmr_period;
              tmr_running = 1'b1;
            end
          end
          REG_PERIOD: tmr_period = cnt_t'(beat.write_data);
          default: ;  // snapshot is read-only
        endcase
      end
      default: ;
    endcase
    res.irq_out = tmr_timeout & tmr_irq_en;
    return res;
  endfunction

  task automatic queue_beat(input logic [1:0] req, input logic [1:0] idx,
                            input logic [DataWidth-1:0] data);
    req_slot_t slot;
    slot.beat.req_type   = req;
    slot.beat.reg_index  = idx;
    slot.beat.write_data = data;
    slot.drain_first     = drain_next;
    drain_next           = 1'b0;
    req_beats.push_back(slot);
  endtask

  // Driver: offer the next beat once the current one is taken; predict at acceptance.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        expected_replies.push_back(timer_step(in_item));
        beats_accepted <= beats_accepted + 1;
      end
      offer = 1'b0;
      if (req_beats.size() != 0) begin
        if (req_beats[0].drain_first) begin
          // Hold off until the block has handed back every result.
          offer = !in_valid && (beats_accepted == results_seen);
        end else if (beats_accepted >= 100 && beats_accepted < 200) begin
          offer = 1'b1;  // stretch with no sender gaps
        end else begin
          offer = ($urandom_range(0, 99) >= IdlePct);
        end
      end
      if (offer) begin
        next_slot = req_beats.pop_front();
        in_item  <= next_slot.beat;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random gaps, one long hold once results start flowing, and a quiet stretch.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && results_seen >= LongHoldAt) begin
      hold_done = 1'b1;
      hold_left = LongHoldLen - 1;
      out_stall <= 1'b1;
    end else if (results_seen >= 250 && results_seen < 350) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < IdlePct);
    end
  end

  // Monitor: compare every accepted result beat with the oldest prediction.
  always @(posedge clk_i or negedge rst_n) begin
    if (rst_n && out_valid && !out_stall) begin
      if (results_seen >= beats_accepted) begin
        $display("%0t: result beat with nothing expected: read_data=%h irq_out=%b",
                 $time, out_item.read_data, out_item.irq_out);
        mismatches++;
      end else begin
        want = expected_replies.pop_front();
        if (out_item.read_data !== want.read_data) begin
          $display("%0t: read_data mismatch, expected %h actual %h",
                   $time, want.read_data, out_item.read_data);
          mismatches++;
        end
        if (out_item.irq_out !== want.irq_out) begin
          $display("%0t: irq_out mismatch, expected %b actual %b",
                   $time, want.irq_out, out_item.irq_out);
          mismatches++;
        end
        if (want.irq_out) irq_results++;
        results_seen <= results_seen + 1;
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d beats in, %0d results out",
               $time, cycle_count, beats_accepted, results_seen);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned random_count;
    int unsigned run_len;
    int unsigned pick;
    logic [DataWidth-1:0] ctl;
    logic [DataWidth-1:0] per;

    // Directed part: reset values, extremes, one-shot and continuous expiry, odd writes.
    queue_beat(REQ_READ, REG_STATUS, '0);
    queue_beat(REQ_READ, REG_CONTROL, '1);
    queue_beat(REQ_READ, REG_PERIOD, '0);
    queue_beat(REQ_READ, REG_SNAPSHOT, '1);
    queue_beat(REQ_WRITE, REG_PERIOD, 32'hFFFF_FFFF);
    queue_beat(REQ_READ, REG_PERIOD, '0);
    queue_beat(REQ_WRITE, REG_PERIOD, 32'd2);
    ctl = '0;
    ctl[CtlIrqEnBit] = 1'b1;
    ctl[CtlStartBit] = 1'b1;
    queue_beat(REQ_WRITE, REG_CONTROL, ctl);  // one-shot with interrupt
    queue_beat(REQ_TICK, REG_STATUS, '1);
    queue_beat(REQ_READ, REG_SNAPSHOT, '0);
    queue_beat(REQ_TICK, REG_CONTROL, '0);    // count of one expires, timer stops
    queue_beat(REQ_READ, REG_STATUS, '0);
    queue_beat(REQ_WRITE, REG_STATUS, '1);    // clear timeout, data ignored
    ctl = '0;
    ctl[CtlStartBit] = 1'b1;
    ctl[CtlStopBit]  = 1'b1;
    queue_beat(REQ_WRITE, REG_CONTROL, ctl);  // start and stop together
    queue_beat(REQ_TICK, REG_PERIOD, '0);     // tick while stopped
    queue_beat(REQ_WRITE, REG_SNAPSHOT, 32'h1234_5678);
    queue_beat(REQ_WRITE, REG_PERIOD, '0);
    ctl = '0;
    ctl[CtlIrqEnBit] = 1'b1;
    ctl[CtlContBit]  = 1'b1;
    ctl[CtlStartBit] = 1'b1;
    queue_beat(REQ_WRITE, REG_CONTROL, ctl);  // continuous with zero period
    queue_beat(REQ_TICK, REG_SNAPSHOT, '0);
    queue_beat(REQ_TICK, REG_SNAPSHOT, '0);
    queue_beat(REQ_READ, REG_SNAPSHOT, '0);
    queue_beat(ReqUnknown, REG_CONTROL, '1);
    queue_beat(REQ_WRITE, REG_CONTROL, 32'hFFFF_FFF3);  // upper bits ignored
    ctl = '0;
    ctl[CtlStopBit] = 1'b1;
    queue_beat(REQ_WRITE, REG_CONTROL, ctl);
    queue_beat(REQ_TICK, REG_STATUS, '0);

    // Random part: mostly program-start-count runs, some pure noise.
    drain_next   = 1'b1;
    random_count = 0;
    while (random_count < RandomBeats) begin
      if (random_count >= RandomBeats / 2 && random_count < RandomBeats / 2 + 20) begin
        drain_next = 1'b1;  // more full drains halfway through
      end
      if ($urandom_range(0, 99) < 75) begin
        per = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 6);
        queue_beat(REQ_WRITE, REG_PERIOD, per);
        ctl = $urandom();
        ctl[CtlStartBit] = 1'b1;
        ctl[CtlStopBit]  = ($urandom_range(0, 9) == 0);
        queue_beat(REQ_WRITE, REG_CONTROL, ctl);
        run_len = $urandom_range(1, 14);
        repeat (run_len) begin
          pick = $urandom_range(0, 99);
          if (pick < 60) begin
            queue_beat(REQ_TICK, 2'($urandom_range(0, 3)), $urandom());
          end else if (pick < 85) begin
            queue_beat(REQ_READ, 2'($urandom_range(0, 3)), $urandom());
          end else if (pick < 93) begin
            queue_beat(REQ_WRITE, REG_STATUS, $urandom());
          end else begin
            queue_beat(REQ_WRITE, REG_CONTROL, $urandom());
          end
        end
        random_count += run_len + 2;
      end else begin
        queue_beat(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom());
        random_count++;
      end
    end

    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;

    // Wait until every beat is in and every result is out, then let the pipe settle.
    while (!(req_beats.size() == 0 && !in_valid && results_seen == beats_accepted)) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);

    if (expected_replies.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_replies.size());
      mismatches++;
    end

    $display("Drove %0d request beats and checked %0d result beats in %0d cycles.",
             beats_accepted, results_seen, cycle_count);
    $display("Timer expired %0d times; %0d results carried the interrupt; %0d mismatches.",
             timeouts_seen, irq_results, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/cit_pkg.sv
rtl/core/cit_core.sv
rtl/core/countdown_interval_timer_top.sv
test/tb_countdown_interval_timer_top.sv
